/* sv/dfq_pkg.sv */
// ----------------------------------------------------------------------------
// dfq_pkg
// Types and constants shared by the duplicate-rejecting queue and its cells.
// ----------------------------------------------------------------------------
package dfq_pkg;

	localparam int DEPTH = 16;
	localparam int VAL_W = 31;
	localparam int DATA_W = 32;
	localparam int STATUS_W = 3;

	localparam logic MODE_INSERT = 1'b0;
	localparam logic MODE_REMOVE = 1'b1;

	localparam logic [STATUS_W-1:0] ST_OK = 3'd0;
	localparam logic [STATUS_W-1:0] ST_NEG = 3'd1;
	localparam logic [STATUS_W-1:0] ST_DUP = 3'd2;
	localparam logic [STATUS_W-1:0] ST_FULL = 3'd3;
	localparam logic [STATUS_W-1:0] ST_EMPTY = 3'd4;

	localparam logic signed [DATA_W-1:0] FAIL_WORD = '1;

	typedef struct packed {
		logic mode;
		logic signed [DATA_W-1:0] value;
	} req_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] result;
		logic [STATUS_W-1:0] status;
	} rsp_t;

	typedef struct packed {
		logic push;
		logic pop;
	} cell_ctrl_t;

endpackage

/* sv/dfq_cell.sv */
// ----------------------------------------------------------------------------
// dfq_cell
// One queue slot: holds an entry, shifts toward the head on a remove, loads
// the new entry when it is the first empty slot, and compares its entry.
// ----------------------------------------------------------------------------
module dfq_cell (
	input  logic                     clk,
	input  logic                     arst_n,
	input  dfq_pkg::cell_ctrl_t      ctrl,
	input  logic [dfq_pkg::VAL_W-1:0] key,
	input  logic                     prev_valid,
	input  logic                     next_valid,
	input  logic [dfq_pkg::VAL_W-1:0] next_value,
	output logic                     valid,
	output logic [dfq_pkg::VAL_W-1:0] value,
	output logic                     match
);
	import dfq_pkg::*;

	logic valid_q;
	logic [VAL_W-1:0] value_q;
	logic load;

	assign load = ctrl.push && !valid_q && prev_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctrl.pop) begin
			valid_q <= next_valid;
		end else if (load) begin
			valid_q <= 1'b1;
		end
	end

	// Hold entry data without reset; occupancy lives in valid_q.
	always_ff @(posedge clk) begin
		if (ctrl.pop) begin
			value_q <= next_value;
		end else if (load) begin
			value_q <= key;
		end
	end

	assign valid = valid_q;
	assign value = value_q;
	assign match = valid_q && (value_q == key);

endmodule

/* sv/dedup_fifo_queue_core.sv */
// ----------------------------------------------------------------------------
// dedup_fifo_queue_core
// First-in first-out queue of non-negative values that refuses duplicates.
// ----------------------------------------------------------------------------
// channel | signals                  | item
// --------+--------------------------+-------------------------------
// request | req_valid, req_ready     | req  (mode, value)
// response| rsp_valid, rsp_ready     | rsp  (result, status)
//
// One item per cycle while responses are taken: each request is resolved in
// the cycle it is accepted and its response is registered; the next request
// can be taken in the cycle after. Every slot compares its entry in parallel,
// and a remove shifts the whole chain of slots one place toward the head. Reset
// empties the queue. A stalled response holds req_ready low until it is taken.
// ----------------------------------------------------------------------------
module dedup_fifo_queue_core (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_ready,
	input  dfq_pkg::req_t  req,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	output dfq_pkg::rsp_t  rsp
);
	import dfq_pkg::*;

	logic [DEPTH-1:0] cell_valid;
	logic [DEPTH-1:0] cell_match;
	logic [VAL_W-1:0] cell_value [DEPTH];
	logic [VAL_W-1:0] key;
	cell_ctrl_t ctrl;
	logic accept;
	logic full;
	logic empty;
	logic dup;
	rsp_t rsp_d;
	rsp_t rsp_q;
	logic rsp_valid_q;

	assign req_ready = !rsp_valid_q || rsp_ready;
	assign accept = req_valid && req_ready;
	assign key = req.value[VAL_W-1:0];

	assign full = cell_valid[DEPTH-1];
	assign empty = !cell_valid[0];
	assign dup = |cell_match;

	always_comb begin
		ctrl = '0;
		rsp_d.result = FAIL_WORD;
		rsp_d.status = ST_OK;
		case (req.mode)
			MODE_INSERT: begin
				if (req.value[DATA_W-1]) begin
					rsp_d.status = ST_NEG;
				end else if (full) begin
					rsp_d.status = ST_FULL;
				end else if (dup) begin
					rsp_d.status = ST_DUP;
				end else begin
					ctrl.push = accept;
					rsp_d.result = req.value;
				end
			end
			MODE_REMOVE: begin
				if (empty) begin
					rsp_d.status = ST_EMPTY;
				end else begin
					ctrl.pop = accept;
					rsp_d.result = {1'b0, cell_value[0]};
				end
			end
			default: begin
				rsp_d.status = ST_OK;
			end
		endcase
	end

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic prev_v;
		logic next_v;
		logic [VAL_W-1:0] next_d;

		if (i == 0) begin : g_head
			assign prev_v = 1'b1;
		end else begin : g_body
			assign prev_v = cell_valid[i-1];
		end

		if (i == DEPTH - 1) begin : g_tail
			assign next_v = 1'b0;
			assign next_d = '0;
		end else begin : g_link
			assign next_v = cell_valid[i+1];
			assign next_d = cell_value[i+1];
		end

		dfq_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctrl       (ctrl),
			.key        (key),
			.prev_valid (prev_v),
			.next_valid (next_v),
			.next_value (next_d),
			.valid      (cell_valid[i]),
			.value      (cell_value[i]),
			.match      (cell_match[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (accept) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp = rsp_q;

endmodule
